// ===== src/pcsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcsp_pkg;

  // Card store geometry and transfer limits
  localparam int unsigned CARD_BYTES   = 131072;
  localparam int unsigned SECTOR_BYTES = 128;
  localparam int unsigned STEP_MAX     = 1023;
  localparam int unsigned STEP_W       = 10;
  localparam int unsigned IDX_W        = $clog2(CARD_BYTES);
  localparam int unsigned ADDR_MAX     = 65535 * SECTOR_BYTES + (STEP_MAX - 4);
  localparam int unsigned ADDR_W       = $clog2(ADDR_MAX + 1);

  // Bus operations
  typedef enum logic [2:0] {
    OP_READ8   = 3'd0,
    OP_READ16  = 3'd1,
    OP_READ32  = 3'd2,
    OP_WRITE8  = 3'd3,
    OP_WRITE16 = 3'd4,
    OP_WRITE32 = 3'd5
  } op_e;

  // Register offsets, one bit wider than the port field to hold offset+2
  localparam logic [5:0] OFF_DATA    = 6'h00;
  localparam logic [5:0] OFF_STAT    = 6'h04;
  localparam logic [5:0] OFF_STAT_HI = 6'h05;
  localparam logic [5:0] OFF_MODE    = 6'h08;
  localparam logic [5:0] OFF_CTRL    = 6'h0A;
  localparam logic [5:0] OFF_BAUD    = 6'h0E;

  // Configuration register indexes
  localparam logic CFG_PAD_CONNECTED = 1'b0;
  localparam logic CFG_CARD_PRESENT  = 1'b1;

  // Selected device
  localparam logic [1:0] DEV_NONE = 2'd0;
  localparam logic [1:0] DEV_PAD  = 2'd1;
  localparam logic [1:0] DEV_CARD = 2'd2;

  // Protocol bytes
  localparam logic [7:0] BYTE_PAD_SEL   = 8'h01;
  localparam logic [7:0] BYTE_PAD_ID    = 8'h41;
  localparam logic [7:0] BYTE_ACK       = 8'h5A;
  localparam logic [7:0] BYTE_CARD_SEL  = 8'h81;
  localparam logic [7:0] BYTE_CMD_READ  = 8'h52;
  localparam logic [7:0] BYTE_CMD_WRITE = 8'h57;
  localparam logic [7:0] BYTE_IDLE      = 8'hFF;
  localparam logic [7:0] BYTE_SEC_ACK   = 8'h5D;
  localparam logic [7:0] BYTE_POLL      = 8'h42;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;

  // Register reset values and bits
  localparam logic [15:0] STAT_RESET = 16'h0005;
  localparam logic [15:0] MODE_RESET = 16'h000D;
  localparam logic [15:0] BAUD_RESET = 16'h0088;
  localparam int unsigned STAT_RX_BIT   = 1;
  localparam int unsigned STAT_ACK_BIT  = 7;
  localparam int unsigned CTRL_SEL_BIT  = 1;
  localparam int unsigned CTRL_RST_BIT  = 6;

  typedef struct packed {
    logic [31:0] data;
    logic        bad;
  } res_t;

endpackage

`default_nettype wire

// ===== src/pad_card_serial_port.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Results are registered into the output register, or into its skid stage.
// Throughput: one transaction per cycle while the skid stage is empty; the card
//   store read is forwarded into the receive byte, so data reads never wait.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the card
//   store one byte a cycle with in_ready_o low.
module pad_card_serial_port import pcsp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic        cfg_data_i,
  // bus transaction in
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [4:0]  byte_offset_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [15:0] pad_buttons_i,
  // result out
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      read_data_o,
  output logic             bad_offset_o
);

  // Architectural registers of the port
  logic [15:0]       status_q, status_d;
  logic [15:0]       mode_q, mode_d;
  logic [15:0]       ctrl_q, ctrl_d;
  logic [15:0]       baud_q, baud_d;
  logic [7:0]        rx_byte_q, rx_byte_d;
  logic              rx_mem_q, rx_mem_d;   // receive byte lives in mem_rd_q
  logic [1:0]        dev_q, dev_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [7:0]        sec_hi_q, sec_hi_d;
  logic [7:0]        sec_lo_q, sec_lo_d;
  logic [ADDR_W-1:0] addr_q, addr_d;       // sector base plus data step
  logic              pad_conn_q, pad_conn_d;
  logic              card_pres_q, card_pres_d;

  // Clearing pass after reset
  logic              clr_active_q, clr_active_d;
  logic [IDX_W-1:0]  clr_idx_q, clr_idx_d;

  // Card store
  logic [7:0]        card_mem [CARD_BYTES];
  logic [7:0]        mem_rd_q;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_idx;
  logic [7:0]        mem_wdata;

  // Output register and skid stage
  logic              ov_q, ov_d;
  logic              sk_v_q, sk_v_d;
  res_t              out_q, out_d;
  res_t              sk_q, sk_d;

  logic              acc;
  res_t              res;
  logic [7:0]        rx_view;
  logic [7:0]        tx;
  logic [5:0]        off;

  // Read one 16-bit register; bit 16 flags an unknown offset.
  function automatic logic [16:0] rd16(input logic [5:0] o, input logic [15:0] st,
                                       input logic [15:0] md, input logic [15:0] ct,
                                       input logic [15:0] bd);
    logic [16:0] r;
    unique case (o)
      OFF_STAT: r = {1'b0, st};
      OFF_MODE: r = {1'b0, md};
      OFF_CTRL: r = {1'b0, ct};
      OFF_BAUD: r = {1'b0, bd};
      default:  r = {1'b1, 16'hFFFF};
    endcase
    return r;
  endfunction

  assign in_ready_o = !clr_active_q && !sk_v_q;
  assign acc        = in_valid_i && in_ready_o;
  assign tx         = write_data_i[7:0];
  assign off        = {1'b0, byte_offset_i};
  // A card read answer lands in the registered mem_rd_q; forward it.
  assign rx_view    = rx_mem_q ? mem_rd_q : rx_byte_q;

  always_comb begin
    logic [16:0]       lo, hi;
    logic [5:0]        off_h;
    logic [15:0]       val_h;
    logic [1:0]        n_half;
    logic [7:0]        resp;
    logic [1:0]        new_dev;
    logic              from_mem;
    logic              in_range;
    logic [15:0]       sector;

    status_d    = status_q;
    mode_d      = mode_q;
    ctrl_d      = ctrl_q;
    baud_d      = baud_q;
    rx_byte_d   = rx_byte_q;
    rx_mem_d    = rx_mem_q;
    dev_d       = dev_q;
    step_d      = step_q;
    cmd_d       = cmd_q;
    sec_hi_d    = sec_hi_q;
    sec_lo_d    = sec_lo_q;
    addr_d      = addr_q;
    pad_conn_d  = pad_conn_q;
    card_pres_d = card_pres_q;
    res         = '0;
    lo          = '0;
    hi          = '0;
    off_h       = '0;
    val_h       = '0;
    n_half      = 2'd0;
    resp        = BYTE_IDLE;
    new_dev     = dev_q;
    from_mem    = 1'b0;
    in_range    = addr_q < ADDR_W'(CARD_BYTES);
    sector      = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_idx     = addr_q[IDX_W-1:0];
    mem_wdata   = tx;

    // Sweep the store to zero after reset
    clr_active_d = clr_active_q;
    clr_idx_d    = clr_idx_q;
    if (clr_active_q) begin
      mem_we    = 1'b1;
      mem_idx   = clr_idx_q;
      mem_wdata = '0;
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == IDX_W'(CARD_BYTES - 1)) begin
        clr_active_d = 1'b0;
      end
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAD_CONNECTED: pad_conn_d  = cfg_data_i;
        CFG_CARD_PRESENT:  card_pres_d = cfg_data_i;
        default: ;
      endcase
    end

    if (acc) begin
      unique case (op_e'(opcode_i))
        OP_READ8: begin
          if (off == OFF_DATA) begin
            status_d[STAT_RX_BIT] = 1'b0;
            res.data = {24'h0, rx_view};
          end else if (off == OFF_STAT) begin
            res.data = {24'h0, status_q[7:0]};
          end else if (off == OFF_STAT_HI) begin
            res.data = {24'h0, status_q[15:8]};
          end else begin
            res.bad  = 1'b1;
            res.data = 32'h0000_00FF;
          end
        end
        OP_READ16: begin
          lo = rd16(off, status_q, mode_q, ctrl_q, baud_q);
          res.data = {16'h0, lo[15:0]};
          res.bad  = lo[16];
        end
        OP_READ32: begin
          lo = rd16(off, status_q, mode_q, ctrl_q, baud_q);
          hi = rd16(off + 6'd2, status_q, mode_q, ctrl_q, baud_q);
          res.data = {hi[15:0], lo[15:0]};
          res.bad  = lo[16] | hi[16];
        end
        OP_WRITE8: begin
          if (off != OFF_DATA) begin
            res.bad = 1'b1;
          end else if (!ctrl_q[CTRL_SEL_BIT]) begin
            // deselected: drop the transfer
            dev_d     = DEV_NONE;
            step_d    = '0;
            rx_byte_d = BYTE_IDLE;
            rx_mem_d  = 1'b0;
          end else begin
            if (step_q == '0) begin
              if (tx == BYTE_PAD_SEL) begin
                new_dev = DEV_PAD;
                resp    = pad_conn_q ? BYTE_PAD_ID : BYTE_IDLE;
              end else if (tx == BYTE_CARD_SEL) begin
                new_dev = DEV_CARD;
                resp    = card_pres_q ? BYTE_ACK : BYTE_IDLE;
              end else begin
                new_dev = DEV_NONE;
              end
              step_d = STEP_W'(1);
            end else begin
              if (dev_q == DEV_PAD) begin
                priority if (step_q == STEP_W'(1)) begin
                  resp = (tx == BYTE_POLL) ? BYTE_ACK : BYTE_IDLE;
                end else if (step_q == STEP_W'(2)) begin
                  resp = pad_buttons_i[15:8];
                end else if (step_q == STEP_W'(3)) begin
                  resp = pad_buttons_i[7:0];
                end else begin
                  resp = BYTE_IDLE;
                end
              end else if (dev_q == DEV_CARD) begin
                // Keep addr_q at sector base plus (step - 5), present or not
                if (step_q == STEP_W'(4)) begin
                  sector = {sec_hi_q, card_pres_q ? tx : sec_lo_q};
                  addr_d = ADDR_W'(ADDR_W'(sector) * ADDR_W'(SECTOR_BYTES));
                end else if (step_q >= STEP_W'(5) && step_q < STEP_W'(STEP_MAX)) begin
                  addr_d = addr_q + 1'b1;
                end
                if (card_pres_q) begin
                  priority if (step_q == STEP_W'(1)) begin
                    cmd_d = tx;
                    resp  = BYTE_ACK;
                  end else if (step_q == STEP_W'(2)) begin
                    resp = BYTE_ACK;
                  end else if (step_q == STEP_W'(3)) begin
                    sec_hi_d = tx;
                    resp     = BYTE_SEC_ACK;
                  end else if (step_q == STEP_W'(4)) begin
                    sec_lo_d = tx;
                    resp     = BYTE_ZERO;
                  end else if (cmd_q == BYTE_CMD_READ) begin
                    if (in_range) begin
                      mem_re   = 1'b1;
                      from_mem = 1'b1;
                    end
                  end else if (cmd_q == BYTE_CMD_WRITE) begin
                    mem_we = in_range;
                    resp   = BYTE_ACK;
                  end
                end
              end
              if (step_q < STEP_W'(STEP_MAX)) begin
                step_d = step_q + 1'b1;
              end
            end
            dev_d     = new_dev;
            rx_byte_d = resp;
            rx_mem_d  = from_mem;
            status_d[STAT_RX_BIT] = 1'b1;
            if (new_dev != DEV_NONE) begin
              status_d[STAT_ACK_BIT] = 1'b1;
            end
          end
        end
        OP_WRITE16, OP_WRITE32: begin
          n_half = (op_e'(opcode_i) == OP_WRITE32) ? 2'd2 : 2'd1;
          // halves always hit different registers, so apply them side by side
          for (int h = 0; h < 2; h++) begin
            if (2'(h) < n_half) begin
              off_h = off + 6'(2 * h);
              val_h = write_data_i[16*h +: 16];
              unique case (off_h)
                OFF_MODE: mode_d = val_h;
                OFF_CTRL: begin
                  ctrl_d = val_h;
                  if (val_h[CTRL_RST_BIT]) begin
                    dev_d    = DEV_NONE;
                    step_d   = '0;
                    status_d = STAT_RESET;
                  end
                  if (!val_h[CTRL_SEL_BIT]) begin
                    dev_d  = DEV_NONE;
                    step_d = '0;
                  end
                end
                OFF_BAUD: baud_d = val_h;
                default:  res.bad = 1'b1;
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    // Output register with a skid stage behind it
    ov_d   = ov_q;
    sk_v_d = sk_v_q;
    out_d  = out_q;
    sk_d   = sk_q;
    if (ov_q && out_ready_i) begin
      if (sk_v_q) begin
        out_d  = sk_q;
        sk_v_d = 1'b0;
      end else begin
        ov_d  = acc;
        out_d = res;
      end
    end else if (!ov_q) begin
      ov_d  = acc;
      out_d = res;
    end else if (acc) begin
      sk_v_d = 1'b1;
      sk_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q     <= STAT_RESET;
      mode_q       <= MODE_RESET;
      ctrl_q       <= '0;
      baud_q       <= BAUD_RESET;
      rx_byte_q    <= '0;
      rx_mem_q     <= 1'b0;
      dev_q        <= DEV_NONE;
      step_q       <= '0;
      cmd_q        <= '0;
      sec_hi_q     <= '0;
      sec_lo_q     <= '0;
      addr_q       <= '0;
      pad_conn_q   <= 1'b1;
      card_pres_q  <= 1'b0;
      clr_active_q <= 1'b1;
      clr_idx_q    <= '0;
      ov_q         <= 1'b0;
      sk_v_q       <= 1'b0;
    end else begin
      status_q     <= status_d;
      mode_q       <= mode_d;
      ctrl_q       <= ctrl_d;
      baud_q       <= baud_d;
      rx_byte_q    <= rx_byte_d;
      rx_mem_q     <= rx_mem_d;
      dev_q        <= dev_d;
      step_q       <= step_d;
      cmd_q        <= cmd_d;
      sec_hi_q     <= sec_hi_d;
      sec_lo_q     <= sec_lo_d;
      addr_q       <= addr_d;
      pad_conn_q   <= pad_conn_d;
      card_pres_q  <= card_pres_d;
      clr_active_q <= clr_active_d;
      clr_idx_q    <= clr_idx_d;
      ov_q         <= ov_d;
      sk_v_q       <= sk_v_d;
    end
  end

  // Result payload holds no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sk_q  <= sk_d;
  end

  // Card store: one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      card_mem[mem_idx] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= card_mem[mem_idx];
    end
  end

  assign out_valid_o  = ov_q;
  assign read_data_o  = out_q.data;
  assign bad_offset_o = out_q.bad;

  // Skid stage only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> ov_q)
    else $error("skid entry valid without output entry");

  // No transaction enters while the store is being cleared
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !in_ready_o)
    else $error("transaction accepted during clearing pass");

  // A card read always forwards its answer into the receive byte
  a_read_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && mem_re) |=> rx_mem_q)
    else $error("card read answer not forwarded");

  // Clearing pass ends only after the last entry
  a_clear_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_active_q) |-> $past(clr_idx_q) == IDX_W'(CARD_BYTES - 1))
    else $error("clearing pass ended early");

  // Outside the clearing sweep, only a card transfer writes the card store
  a_write_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !clr_active_q) |-> (acc && dev_q == DEV_CARD))
    else $error("card store written outside a card transfer");

endmodule

`default_nettype wire
